// ----- rtl/assert_macros.svh -----
// assertion macros for the track parser rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define MTEP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtep_pkg.sv -----
// shared types and constants for the midi track event parser
// no dependencies; imported by every module of the block
package mtep_pkg;

  // longest vlq before the overflow flag is raised
  localparam int VLQ_BYTES = 4;
  localparam int VLQ_CNT_W = $clog2(VLQ_BYTES + 1);

  localparam logic [7:0] STATUS_META    = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_E = 8'hF7;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_PROG     = 8'hC0;
  localparam logic [7:0] STATUS_PITCH    = 8'hE0;
  localparam logic [7:0] STATUS_SYSTEM   = 8'hF0;
  localparam logic [7:0] META_END_TRACK = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [6:0] DATA_MASK      = 7'h7F;

  typedef enum logic [2:0] {
    KIND_NOTE_ON    = 3'd0,
    KIND_NOTE_OFF   = 3'd1,
    KIND_TEMPO      = 3'd2,
    KIND_END_TRACK  = 3'd3,
    KIND_META       = 3'd4,
    KIND_SYSEX      = 3'd5,
    KIND_OTHER_CHAN = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [27:0] delta_ticks;
    logic [7:0]  status_value;
    logic [3:0]  channel;
    logic [6:0]  key_number;
    logic [6:0]  velocity;
    logic [23:0] tempo_us;
    logic [7:0]  meta_type;
    logic        vlq_overflow;
  } mtep_result_t;

  typedef struct packed {
    logic emit;
    logic halted;
  } mtep_status_t;

endpackage

// ----- rtl/mtep_parser.sv -----
// byte-wise parse state machine: one byte per take, one event result on completion
// depends on mtep_pkg
module mtep_parser
  import mtep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   byte_in,
  output mtep_status_t status,
  output mtep_result_t result
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
    PH_META_BODY, PH_SYSEX_LEN, PH_SYSEX_BODY, PH_HALT
  } phase_t;

  phase_t               phase, phase_next;
  logic [27:0]          delta_accum, delta_accum_next;
  logic [7:0]           status_hold, status_hold_next;
  logic [7:0]           meta_type_hold, meta_type_hold_next;
  logic [27:0]          bytes_to_skip, bytes_to_skip_next;
  logic [6:0]           first_data, first_data_next;
  logic [23:0]          tempo_accum, tempo_accum_next;
  logic [VLQ_CNT_W-1:0] vlq_count, vlq_count_next;
  logic                 overflow_seen, overflow_seen_next;

  logic        emit;
  kind_t       kind, meta_kind, chan_kind;
  logic [6:0]  key, vel;
  logic [27:0] vlq_src, vlq_shift, skip_dec;
  logic        vlq_done, is_chan;

  // one vlq group shifts in, the source depends on the phase
  assign vlq_src   = (phase == PH_DELTA) ? delta_accum : bytes_to_skip;
  assign vlq_shift = {vlq_src[20:0], byte_in[6:0]};
  assign vlq_done  = ~byte_in[7];
  assign skip_dec  = bytes_to_skip - 28'd1;
  assign is_chan   = (status_hold >= STATUS_NOTE_OFF) && (status_hold < STATUS_SYSTEM);

  always_comb begin
    priority if (meta_type_hold == META_END_TRACK) meta_kind = KIND_END_TRACK;
    else if (meta_type_hold == META_TEMPO)         meta_kind = KIND_TEMPO;
    else                                           meta_kind = KIND_META;
  end

  always_comb begin
    priority if (status_hold[7:4] == STATUS_NOTE_ON[7:4])  chan_kind = KIND_NOTE_ON;
    else if (status_hold[7:4] == STATUS_NOTE_OFF[7:4])     chan_kind = KIND_NOTE_OFF;
    else                                                   chan_kind = KIND_OTHER_CHAN;
  end

  always_comb begin
    phase_next          = phase;
    delta_accum_next    = delta_accum;
    status_hold_next    = status_hold;
    meta_type_hold_next = meta_type_hold;
    bytes_to_skip_next  = bytes_to_skip;
    first_data_next     = first_data;
    tempo_accum_next    = tempo_accum;
    vlq_count_next      = vlq_count;
    overflow_seen_next  = overflow_seen;
    emit = 1'b0;
    kind = KIND_OTHER_CHAN;
    key  = '0;
    vel  = '0;

    unique case (phase)
      PH_DELTA: begin
        delta_accum_next = vlq_shift;
        if (vlq_count < VLQ_CNT_W'(VLQ_BYTES)) vlq_count_next = vlq_count + 1'b1;
        else overflow_seen_next = 1'b1;
        if (vlq_done) begin
          vlq_count_next = '0;
          phase_next     = PH_STATUS;
        end
      end
      PH_STATUS: begin
        status_hold_next    = byte_in;
        meta_type_hold_next = '0;
        priority if (byte_in == STATUS_META) begin
          phase_next = PH_META_TYPE;
        end else if (byte_in == STATUS_SYSEX || byte_in == STATUS_SYSEX_E) begin
          bytes_to_skip_next = '0;
          vlq_count_next     = '0;
          phase_next         = PH_SYSEX_LEN;
        end else begin
          phase_next = PH_DATA1;
        end
      end
      PH_DATA1: begin
        first_data_next = byte_in[6:0] & DATA_MASK;
        // program change and channel pressure end after one data byte
        if (status_hold >= STATUS_PROG && status_hold < STATUS_PITCH) begin
          emit = 1'b1;
          kind = KIND_OTHER_CHAN;
          key  = byte_in[6:0];
        end else begin
          phase_next = PH_DATA2;
        end
      end
      PH_DATA2: begin
        emit = 1'b1;
        kind = chan_kind;
        key  = first_data;
        vel  = byte_in[6:0];
      end
      PH_META_TYPE: begin
        meta_type_hold_next = byte_in;
        phase_next          = PH_META_LEN;
      end
      PH_META_LEN: begin
        bytes_to_skip_next = {20'd0, byte_in};
        tempo_accum_next   = '0;
        if (byte_in == 8'd0) begin
          emit = 1'b1;
          kind = meta_kind;
        end else begin
          phase_next = PH_META_BODY;
        end
      end
      PH_META_BODY: begin
        if (meta_type_hold == META_TEMPO) tempo_accum_next = {tempo_accum[15:0], byte_in};
        bytes_to_skip_next = skip_dec;
        if (skip_dec == 28'd0) begin
          emit = 1'b1;
          kind = meta_kind;
        end
      end
      PH_SYSEX_LEN: begin
        bytes_to_skip_next = vlq_shift;
        if (vlq_count < VLQ_CNT_W'(VLQ_BYTES)) vlq_count_next = vlq_count + 1'b1;
        else overflow_seen_next = 1'b1;
        if (vlq_done) begin
          if (vlq_shift == 28'd0) begin
            emit = 1'b1;
            kind = KIND_SYSEX;
          end else begin
            phase_next = PH_SYSEX_BODY;
          end
        end
      end
      PH_SYSEX_BODY: begin
        bytes_to_skip_next = skip_dec;
        if (skip_dec == 28'd0) begin
          emit = 1'b1;
          kind = KIND_SYSEX;
        end
      end
      PH_HALT: begin
      end
      default: begin
        phase_next = PH_DELTA;
      end
    endcase

    result.kind         = kind;
    result.delta_ticks  = delta_accum_next;
    result.status_value = status_hold;
    result.channel      = is_chan ? status_hold[3:0] : 4'd0;
    result.key_number   = key;
    result.velocity     = vel;
    result.tempo_us     = (kind == KIND_TEMPO) ? tempo_accum_next : 24'd0;
    result.meta_type    = (status_hold == STATUS_META) ? meta_type_hold : 8'd0;
    result.vlq_overflow = overflow_seen_next;

    // event done: clear the per-event accumulators
    if (emit) begin
      delta_accum_next   = '0;
      bytes_to_skip_next = '0;
      first_data_next    = '0;
      tempo_accum_next   = '0;
      vlq_count_next     = '0;
      overflow_seen_next = 1'b0;
      phase_next         = (kind == KIND_END_TRACK) ? PH_HALT : PH_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      delta_accum    <= '0;
      status_hold    <= '0;
      meta_type_hold <= '0;
      bytes_to_skip  <= '0;
      first_data     <= '0;
      tempo_accum    <= '0;
      vlq_count      <= '0;
      overflow_seen  <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      delta_accum    <= delta_accum_next;
      status_hold    <= status_hold_next;
      meta_type_hold <= meta_type_hold_next;
      bytes_to_skip  <= bytes_to_skip_next;
      first_data     <= first_data_next;
      tempo_accum    <= tempo_accum_next;
      vlq_count      <= vlq_count_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

  assign status.emit   = emit;
  assign status.halted = (phase == PH_HALT);

endmodule

// ----- rtl/mtep_out_reg.sv -----
// result register on the output channel, holds a beat while the sink stalls
// depends on mtep_pkg
module mtep_out_reg
  import mtep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  mtep_result_t res_in,
  input  logic         out_stall,
  output logic         out_valid,
  output mtep_result_t res_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

// ----- rtl/midi_track_event_parser_top.sv -----
// top level of the midi track event parser: input byte register, parser, result register
// depends on mtep_pkg, mtep_parser, mtep_out_reg and assert_macros.svh
//
// Takes the bytes of a track chunk body one beat at a time and gives one result beat per
// completed event (note on/off, other channel message, tempo, other meta, sysex, end of
// track). Each byte is one beat on the input. While the output is free the block takes
// one byte per cycle. The byte that completes an event sits in the input register, and the
// parse state machine finishes it in a single pass into the result register. While a
// result waits on a stalled output the input register holds its byte and stalls the
// input. Bytes that complete no event give no result. After end of track every further
// byte is accepted and dropped until reset. Running status is not supported; a delta or
// sysex length longer than four groups keeps its low 28 bits and sets vlq_overflow on
// that event.
`include "assert_macros.svh"

module midi_track_event_parser_top
  import mtep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [27:0] delta_ticks,
  output logic [7:0]  status_value,
  output logic [3:0]  channel,
  output logic [6:0]  key_number,
  output logic [6:0]  velocity,
  output logic [23:0] tempo_us,
  output logic [7:0]  meta_type,
  output logic        vlq_overflow
);

  // input register
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         advance;
  mtep_status_t pstat;
  mtep_result_t pres;
  mtep_result_t res_q;

  // the held byte is parsed once the result register has room for it
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
  end

  mtep_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .byte_in (s1_byte),
    .status  (pstat),
    .result  (pres)
  );

  mtep_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && pstat.emit),
    .res_in    (pres),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  // result fields onto their own ports
  assign event_kind   = res_q.kind;
  assign delta_ticks  = res_q.delta_ticks;
  assign status_value = res_q.status_value;
  assign channel      = res_q.channel;
  assign key_number   = res_q.key_number;
  assign velocity     = res_q.velocity;
  assign tempo_us     = res_q.tempo_us;
  assign meta_type    = res_q.meta_type;
  assign vlq_overflow = res_q.vlq_overflow;

  // checks on the block's own control
  `MTEP_ASSERT_IMPL(a_stall_needs_byte, clk, rst, in_stall, s1_valid, "stall with empty input register")
  `MTEP_ASSERT_IMPL(a_halt_silent, clk, rst, pstat.halted, !pstat.emit, "event emitted after end of track")
  `MTEP_ASSERT_NEXT(a_eot_halts, clk, rst, advance && pstat.emit && (pres.kind == KIND_END_TRACK), pstat.halted, "end of track did not halt parser")
  `MTEP_ASSERT_IMPL(a_kind_legal, clk, rst, out_valid, event_kind != 3'd7, "unused event kind on output")

endmodule

// ----- test/tb.sv -----
// self-checking bench for midi_track_event_parser_top: random track streams, per-field checks
// depends on mtep_pkg and the parser rtl; an event ledger class tracks expected events
module tb;
  import mtep_pkg::*;

  localparam int          CYCLE_LIMIT      = 400000;
  localparam int          RANDOM_BYTES     = 400;
  localparam int          MAX_REPORTS      = 10;
  localparam int          TAIL_CYCLES      = 8;
  localparam logic [7:0]  STATUS_KEY_PRESS = 8'hA0;

  // where the byte-level parse currently stands
  typedef enum {
    AWAIT_DELTA, AWAIT_STATUS, AWAIT_DATA1, AWAIT_DATA2, AWAIT_META_TYPE,
    AWAIT_META_LEN, IN_META_BODY, AWAIT_SYSEX_LEN, IN_SYSEX_BODY, HALTED
  } parse_phase_t;

  // tracks the parse of every accepted beat and holds the events still owed by the block
  class event_ledger_t;
    mtep_result_t            due_events[$];
    int unsigned             bad_count;
    parse_phase_t            phase;
    logic [27:0]             delta_acc;
    logic [7:0]              status_byte;
    logic [7:0]              meta_id;
    logic [27:0]             skip_left;
    logic [6:0]              data_first;
    logic [23:0]             tempo_acc;
    logic [VLQ_CNT_W-1:0]    group_cnt;
    logic                    ovf;

    function new();
      phase       = AWAIT_DELTA;
      delta_acc   = '0;
      status_byte = '0;
      meta_id     = '0;
      skip_left   = '0;
      data_first  = '0;
      tempo_acc   = '0;
      group_cnt   = '0;
      ovf         = 1'b0;
      bad_count   = 0;
    endfunction

    function void flag(string what);
      bad_count++;
      if (bad_count <= MAX_REPORTS) $display("mismatch: %s", what);
    endfunction

    // counts a vlq group, saturating and raising overflow past the limit
    function void bump_groups();
      if (group_cnt < VLQ_BYTES) group_cnt++;
      else ovf = 1'b1;
    endfunction

    function void push_event(kind_t k, logic [6:0] key, logic [6:0] vel);
      mtep_result_t r;
      r.kind         = k;
      r.delta_ticks  = delta_acc;
      r.status_value = status_byte;
      r.channel      = (status_byte >= STATUS_NOTE_OFF && status_byte < STATUS_SYSTEM) ?
                       status_byte[3:0] : 4'd0;
      r.key_number   = key;
      r.velocity     = vel;
      r.tempo_us     = (k == KIND_TEMPO) ? tempo_acc : 24'd0;
      r.meta_type    = (status_byte == STATUS_META) ? meta_id : 8'd0;
      r.vlq_overflow = ovf;
      due_events.push_back(r);
      delta_acc  = '0;
      skip_left  = '0;
      data_first = '0;
      tempo_acc  = '0;
      group_cnt  = '0;
      ovf        = 1'b0;
      phase      = (k == KIND_END_TRACK) ? HALTED : AWAIT_DELTA;
    endfunction

    function void close_meta();
      if (meta_id == META_END_TRACK) push_event(KIND_END_TRACK, 7'd0, 7'd0);
      else if (meta_id == META_TEMPO) push_event(KIND_TEMPO, 7'd0, 7'd0);
      else push_event(KIND_META, 7'd0, 7'd0);
    endfunction

    // one accepted input beat
    function void take_byte(logic [7:0] b);
      case (phase)
        AWAIT_DELTA: begin
          bump_groups();
          delta_acc = {delta_acc[20:0], b[6:0]};
          if (!b[7]) begin
            group_cnt = '0;
            phase = AWAIT_STATUS;
          end
        end
        AWAIT_STATUS: begin
          status_byte = b;
          meta_id = '0;
          if (b == STATUS_META) begin
            phase = AWAIT_META_TYPE;
          end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_E) begin
            skip_left = '0;
            group_cnt = '0;
            phase = AWAIT_SYSEX_LEN;
          end else begin
            phase = AWAIT_DATA1;
          end
        end
        AWAIT_DATA1: begin
          data_first = b[6:0];
          if (status_byte >= STATUS_PROG && status_byte < STATUS_PITCH)
            push_event(KIND_OTHER_CHAN, data_first, 7'd0);
          else
            phase = AWAIT_DATA2;
        end
        AWAIT_DATA2: begin
          if (status_byte[7:4] == STATUS_NOTE_ON[7:4])
            push_event(KIND_NOTE_ON, data_first, b[6:0]);
          else if (status_byte[7:4] == STATUS_NOTE_OFF[7:4])
            push_event(KIND_NOTE_OFF, data_first, b[6:0]);
          else
            push_event(KIND_OTHER_CHAN, data_first, b[6:0]);
        end
        AWAIT_META_TYPE: begin
          meta_id = b;
          phase = AWAIT_META_LEN;
        end
        AWAIT_META_LEN: begin
          skip_left = {20'd0, b};
          tempo_acc = '0;
          if (b == 8'd0) close_meta();
          else phase = IN_META_BODY;
        end
        IN_META_BODY: begin
          if (meta_id == META_TEMPO) tempo_acc = {tempo_acc[15:0], b};
          skip_left = skip_left - 28'd1;
          if (skip_left == '0) close_meta();
        end
        AWAIT_SYSEX_LEN: begin
          bump_groups();
          skip_left = {skip_left[20:0], b[6:0]};
          if (!b[7]) begin
            if (skip_left == '0) push_event(KIND_SYSEX, 7'd0, 7'd0);
            else phase = IN_SYSEX_BODY;
          end
        end
        IN_SYSEX_BODY: begin
          skip_left = skip_left - 28'd1;
          if (skip_left == '0) push_event(KIND_SYSEX, 7'd0, 7'd0);
        end
        default: ;
      endcase
    endfunction

    function void field_ok(string name, logic [27:0] want, logic [27:0] seen);
      if (want !== seen)
        flag($sformatf("%s expected %0h got %0h", name, want, seen));
    endfunction

    // one accepted result beat against the oldest event owed
    function void match_event(mtep_result_t got);
      mtep_result_t want;
      if (due_events.size() == 0) begin
        flag($sformatf("result beat with no event due, kind %0d", got.kind));
        return;
      end
      want = due_events.pop_front();
      field_ok("event_kind", 28'(want.kind), 28'(got.kind));
      field_ok("delta_ticks", want.delta_ticks, got.delta_ticks);
      field_ok("status_value", 28'(want.status_value), 28'(got.status_value));
      field_ok("channel", 28'(want.channel), 28'(got.channel));
      field_ok("key_number", 28'(want.key_number), 28'(got.key_number));
      field_ok("velocity", 28'(want.velocity), 28'(got.velocity));
      field_ok("tempo_us", 28'(want.tempo_us), 28'(got.tempo_us));
      field_ok("meta_type", 28'(want.meta_type), 28'(got.meta_type));
      field_ok("vlq_overflow", 28'(want.vlq_overflow), 28'(got.vlq_overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [27:0] delta_ticks;
  logic [7:0]  status_value;
  logic [3:0]  channel;
  logic [6:0]  key_number;
  logic [6:0]  velocity;
  logic [23:0] tempo_us;
  logic [7:0]  meta_type;
  logic        vlq_overflow;

  int unsigned   cycle_cnt = 0;
  logic [7:0]    track_q[$];
  event_ledger_t ledger;

  midi_track_event_parser_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .delta_ticks(delta_ticks), .status_value(status_value),
    .channel(channel), .key_number(key_number), .velocity(velocity),
    .tempo_us(tempo_us), .meta_type(meta_type), .vlq_overflow(vlq_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: a hung block or a lost result ends the run here
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle stretch length: mostly from the short range, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 24);
  endfunction

  // vlq with the given number of groups, most significant group first;
  // groups above the 28-bit range are still sent so over-long values wrap
  function automatic void put_vlq(logic [63:0] v, int groups);
    for (int g = groups - 1; g >= 0; g--)
      track_q.push_back({g != 0, v[7*g +: 7]});
  endfunction

  // mostly clean 7-bit data, sometimes a stray byte with the top bit set
  function automatic logic [7:0] data_val();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 127));
  endfunction

  function automatic void put_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) put_vlq({$urandom, $urandom}, 1);
    else if (r < 85) put_vlq({$urandom, $urandom}, 2);
    else if (r < 95) put_vlq({$urandom, $urandom}, $urandom_range(3, 4));
    else put_vlq({$urandom, $urandom}, $urandom_range(5, 7));
  endfunction

  // one event with random content, now and then malformed; end of track is kept for the close
  function automatic void put_event();
    int          r, len, groups;
    logic [7:0]  st, mt;
    put_delta();
    r = $urandom_range(0, 99);
    if (r < 58) begin
      if (r < 25)      st = STATUS_NOTE_OFF + 8'($urandom_range(0, 31));
      else if (r < 38) st = STATUS_PROG + 8'($urandom_range(0, 31));
      else if (r < 43) st = STATUS_KEY_PRESS + 8'($urandom_range(0, 31));
      else if (r < 48) st = STATUS_PITCH + 8'($urandom_range(0, 15));
      else if (r < 53) begin
        // system range other than the sysex openers
        st = STATUS_SYSTEM + 8'($urandom_range(1, 14));
        if (st == STATUS_SYSEX_E) st = STATUS_SYSTEM + 8'd1;
      end else begin
        st = 8'($urandom_range(0, 127));     // broken: data value in the status slot
      end
      track_q.push_back(st);
      track_q.push_back(data_val());
      if (!(st >= STATUS_PROG && st < STATUS_PITCH)) track_q.push_back(data_val());
    end else if (r < 80) begin
      mt = ($urandom_range(0, 9) < 4) ? META_TEMPO : 8'($urandom_range(0, 255));
      if (mt == META_END_TRACK) mt = META_TEMPO;
      len = (mt == META_TEMPO && $urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 6);
      track_q.push_back(STATUS_META);
      track_q.push_back(mt);
      track_q.push_back(8'(len));
      repeat (len) track_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 9);
      groups = (r < 7) ? 1 : (r < 9) ? $urandom_range(2, 4) : $urandom_range(5, 6);
      len = $urandom_range(0, 6);
      track_q.push_back($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_SYSEX_E);
      put_vlq(64'(len), groups);
      repeat (len) track_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_track();
    // note on at full key and velocity, no delay
    track_q.push_back(8'h00);
    track_q.push_back({STATUS_NOTE_ON[7:4], 4'hF});
    track_q.push_back(8'h7F);
    track_q.push_back(8'h7F);
    // note off at the bottom of every field, longest one-byte delay
    track_q.push_back(8'h7F);
    track_q.push_back(STATUS_NOTE_OFF);
    track_q.push_back(8'h00);
    track_q.push_back(8'h00);
    // largest four-group delay, program change with a top-bit data byte
    put_vlq(64'h0FFF_FFFF, 4);
    track_q.push_back(STATUS_PROG + 8'd5);
    track_q.push_back(8'h80);
    // tempo at its maximum value
    track_q.push_back(8'h00);
    track_q.push_back(STATUS_META);
    track_q.push_back(META_TEMPO);
    track_q.push_back(8'd3);
    repeat (3) track_q.push_back(8'hFF);
    // five-group delay raises overflow; empty sysex closes on its length
    put_vlq(64'd1, 5);
    track_q.push_back(STATUS_SYSEX);
    track_q.push_back(8'h00);
    while (track_q.size() < RANDOM_BYTES + 28) put_event();
    // end of track, then a few beats that must be dropped
    put_delta();
    track_q.push_back(STATUS_META);
    track_q.push_back(META_END_TRACK);
    track_q.push_back(8'd1);
    track_q.push_back(8'($urandom_range(0, 255)));
    repeat (4) track_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // input side: beats go out in order, with bursts and idle gaps mixed
  task automatic feed_track();
    int run_left, gap;
    bit quiet, took;
    run_left = 0;
    quiet = 1'b0;
    foreach (track_q[i]) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        quiet = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      gap = (quiet || $urandom_range(0, 9) < 6) ? 0 : idle_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= track_q[i];
      // stall is read mid-cycle, where it already holds its value for the next edge
      do begin
        @(negedge clk);
        took = !in_stall;
        @(posedge clk);
      end while (!took);
      ledger.take_byte(track_q[i]);
    end
    in_valid <= 1'b0;
  endtask

  // output side back-pressure: calm stretches, short stalls and the odd long one
  initial begin : out_pacing
    int hold, calm_left, r;
    hold = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          calm_left = $urandom_range(10, 60);
          out_stall <= 1'b0;
        end else if (r < 4) begin
          hold = idle_len() - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result beats are taken mid-cycle, with stall and payload settled for the edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall)
      ledger.match_event({event_kind, delta_ticks, status_value, channel, key_number,
                          velocity, tempo_us, meta_type, vlq_overflow});
  end

  initial begin : main_seq
    ledger = new();
    build_track();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    feed_track();
    while (ledger.due_events.size() != 0) @(posedge clk);
    // let anything stray drain past the output latency
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
